// File: rtl/sfs_pkg.sv
// Shared types, widths and codes for the sprite frame sequencer.
`default_nettype none

package sfs_pkg;

  localparam int OP_W       = 3;
  localparam int DT_W       = 24;
  localparam int IDX_W      = 6;
  localparam int DUR_W      = 26;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int POS_W      = CNT_W;
  localparam int FRAME_W    = 6;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam int S_DATA_W   = 64;
  localparam int M_DATA_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_WRITE_DUR = 3'd1,
    OP_RESTART   = 3'd2,
    OP_TOGGLE    = 3'd3,
    OP_SELECT    = 3'd4
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOP      = 2'd0,
    MODE_ONCE      = 2'd1,
    MODE_PING_PONG = 2'd2,
    MODE_HOLD      = 2'd3
  } mode_e;

  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_MODE   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COUNT = 1'b1;

  typedef struct packed {
    logic start;     // word accepted this cycle
    logic step;      // one frame step attempt
    logic load_out;  // capture result into output register
  } sfs_cmd_t;

  typedef struct packed {
    logic go_step;   // accepted word is a tick that has work to do
    logic stop;      // stepping ends after this cycle
  } sfs_stat_t;

endpackage

`default_nettype wire

// File: rtl/sfs_ctrl.sv
// Control state machine and output valid for the sprite frame sequencer.
`default_nettype none

module sfs_ctrl
  import sfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  wire logic      m_tready_i,
  input  wire sfs_stat_t stat_i,
  output sfs_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free       = !out_valid_q || m_tready_i;
  assign s_tready_o      = (state_q == ST_IDLE);
  assign m_tvalid_o      = out_valid_q;
  assign cmd_o.start     = (state_q == ST_IDLE) && s_tvalid_i;
  assign cmd_o.step      = (state_q == ST_STEP);
  assign cmd_o.load_out  = (state_q == ST_FIN) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            state_q <= stat_i.go_step ? ST_STEP : ST_FIN;
          end
        end
        ST_STEP: begin
          if (stat_i.stop) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfs_datapath.sv
// Duration memory, frame position/time state, step logic and result register.
`default_nettype none

module sfs_datapath
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES   = 64,
  parameter int MAX_STEPS    = 128,
  parameter int MIN_DURATION = 1000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sfs_cmd_t              cmd_i,
  output sfs_stat_t                  stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [OP_W-1:0]       op_i,
  input  wire logic [DT_W-1:0]       dt_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire logic [DUR_W-1:0]      dur_i,
  output logic [FRAME_W-1:0]         cur_frame_o,
  output logic                       playing_o,
  output logic [TIME_W-1:0]          time_o,
  output logic                       changed_o
);

  localparam int AW       = $clog2(MAX_FRAMES);
  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int CAP      = (MAX_FRAMES > CNT_MAX) ? CNT_MAX : MAX_FRAMES;
  localparam int SW       = $clog2(MAX_STEPS + 1);
  localparam logic [CNT_W-1:0] CLIP_MAX  = CNT_W'(CAP);
  localparam logic [SW-1:0]    LAST_STEP = SW'(MAX_STEPS - 1);
  localparam logic [DUR_W-1:0] MIN_DUR   = DUR_W'(MIN_DURATION);

  logic [DUR_W-1:0]  mem [MAX_FRAMES];
  logic [DUR_W-1:0]  rd_q;

  mode_e             mode_q;
  logic [CNT_W-1:0]  fcount_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  pos_before_q, pos_before_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic              back_q, back_d;
  logic              play_q, play_d;
  logic [SW-1:0]     steps_q, steps_d;

  logic [FRAME_W-1:0] cur_q;
  logic               play_out_q;
  logic [TIME_W-1:0]  time_out_q;
  logic               chg_q;

  op_e               op;
  logic [CNT_W-1:0]  clip;
  logic [POS_W-1:0]  last_pos;
  logic              tick_active;
  logic [DUR_W-1:0]  dur;
  logic [TIME_W-1:0] dur_t;
  logic              below;
  logic [POS_W-1:0]  pos_inc;
  logic              at_end;
  logic              ping;
  logic              terminal;
  logic [TIME_W:0]   sum;
  logic              idx_ok;
  logic [IDX_W+AW-1:0] widx;
  logic [POS_W+AW-1:0] wpos;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;

  assign op          = op_e'(op_i);
  assign clip        = (fcount_q > CLIP_MAX) ? CLIP_MAX : fcount_q;
  assign last_pos    = clip - CNT_W'(1);
  assign tick_active = play_q && (clip != '0) && (dt_i != '0);
  assign dur         = (rd_q < MIN_DUR) ? MIN_DUR : rd_q;
  assign dur_t       = {{(TIME_W-DUR_W){1'b0}}, dur};
  assign below       = time_q < dur_t;
  assign pos_inc     = pos_q + POS_W'(1);
  assign at_end      = pos_inc >= clip;
  assign ping        = (mode_q == MODE_PING_PONG) && (clip > CNT_W'(1));
  // once, hold, and single-frame ping pong stop at the last frame
  assign terminal    = (mode_q != MODE_LOOP) && !ping && at_end;
  assign sum         = {1'b0, time_q} + {{(TIME_W+1-DT_W){1'b0}}, dt_i};
  assign idx_ok      = 32'(idx_i) < 32'(MAX_FRAMES);
  assign widx        = {{AW{1'b0}}, idx_i};
  assign wpos        = {{AW{1'b0}}, pos_d};
  assign waddr       = widx[AW-1:0];
  assign raddr       = wpos[AW-1:0];

  assign stat_o.go_step = (op == OP_TICK) && tick_active;
  assign stat_o.stop    = below || terminal || (steps_q == LAST_STEP);

  always_comb begin
    pos_d        = pos_q;
    pos_before_d = pos_before_q;
    time_d       = time_q;
    back_d       = back_q;
    play_d       = play_q;
    steps_d      = steps_q;
    if (cmd_i.start) begin
      pos_before_d = pos_q;
      steps_d      = '0;
      case (op)
        OP_TICK: begin
          if (tick_active) begin
            if (pos_q > last_pos) begin
              pos_d = last_pos;
            end
            time_d = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          end
        end
        OP_RESTART: begin
          pos_d  = '0;
          back_d = 1'b0;
          time_d = '0;
          play_d = 1'b1;
        end
        OP_TOGGLE: begin
          play_d = !play_q;
        end
        OP_SELECT: begin
          if ({1'b0, idx_i} < clip) begin
            pos_d  = {1'b0, idx_i};
            time_d = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.step && !below) begin
      time_d  = time_q - dur_t;
      steps_d = steps_q + SW'(1);
      if (mode_q == MODE_LOOP) begin
        pos_d = at_end ? '0 : pos_inc;
      end else if (ping) begin
        if (!back_q) begin
          if (at_end) begin
            back_d = 1'b1;
            pos_d  = clip - CNT_W'(2);
          end else begin
            pos_d = pos_inc;
          end
        end else begin
          if (pos_q == '0) begin
            back_d = 1'b0;
            pos_d  = POS_W'(1);
          end else begin
            pos_d = pos_q - POS_W'(1);
          end
        end
      end else if (!at_end) begin
        pos_d = pos_inc;
      end else begin
        play_d = 1'b0;
        time_d = (mode_q == MODE_HOLD) ? dur_t : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_LOOP;
      fcount_q     <= '0;
      pos_q        <= '0;
      pos_before_q <= '0;
      time_q       <= '0;
      back_q       <= 1'b0;
      play_q       <= 1'b0;
      steps_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_LOOP_MODE) begin
          mode_q <= mode_e'(cfg_data_i[MODE_W-1:0]);
        end else if (cfg_addr_i == REG_FRAME_COUNT) begin
          fcount_q <= cfg_data_i[CNT_W-1:0];
        end
      end
      pos_q        <= pos_d;
      pos_before_q <= pos_before_d;
      time_q       <= time_d;
      back_q       <= back_d;
      play_q       <= play_d;
      steps_q      <= steps_d;
    end
  end

  // read address follows the next position, so rd_q matches pos_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && (op == OP_WRITE_DUR) && idx_ok) begin
      mem[waddr] <= dur_i;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cur_q      <= pos_q[FRAME_W-1:0];
      play_out_q <= play_q;
      time_out_q <= time_q;
      chg_q      <= pos_q != pos_before_q;
    end
  end

  assign cur_frame_o = cur_q;
  assign playing_o   = play_out_q;
  assign time_o      = time_out_q;
  assign changed_o   = chg_q;

endmodule

`default_nettype wire

// File: rtl/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: controller plus datapath.
//
// Usage:
//   Input words arrive on s_tvalid_i/s_tready_o/s_tdata_i, one command each:
//   tick, write duration, restart, toggle play or select frame. Every word
//   yields exactly one result word on m_tvalid_o/m_tready_i/m_tdata_o with
//   the current frame, playing flag, time in frame and a frame-changed flag.
//   loop_mode and frame_count are set through cfg_we_i/cfg_addr_i/cfg_data_i
//   while the block is idle.
// Timing:
//   A non-tick word goes from ST_IDLE to ST_FIN and is loaded into the output
//   register from ST_FIN once the output register is free, which raises
//   m_tvalid_o. A tick with work to do first runs the compare/subtract loop in
//   ST_STEP, fed by the registered duration memory read, with at most MAX_STEPS
//   frame steps; the loop ends on a final compare, the step limit or the end of
//   the clip. One word is worked on at a time; the next word can be accepted
//   once the block is back in ST_IDLE after the load.
// Reset and stall:
//   Reset clears position, time, direction, play flag and registers; the
//   duration memory holds garbage until written. A stalled result holds in
//   the output register; the block can accept and finish one more word, then
//   waits with s_tready_o low until the output register frees up.
`default_nettype none

module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES   = 64,
  parameter int MAX_STEPS    = 128,
  parameter int MIN_DURATION = 1000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  // [2:0] opcode, [26:3] delta_time, [32:27] frame_index,
  // [58:33] frame_duration, [63:59] zero
  input  wire logic [S_DATA_W-1:0]   s_tdata_i,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  // [5:0] current_frame, [6] is_playing, [38:7] time_in_frame,
  // [39] frame_changed
  output logic [M_DATA_W-1:0]        m_tdata_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  sfs_cmd_t           cmd;
  sfs_stat_t          stat;
  logic [FRAME_W-1:0] cur_frame;
  logic               playing;
  logic [TIME_W-1:0]  time_in_frame;
  logic               changed;

  sfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfs_datapath #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_STEPS    (MAX_STEPS),
    .MIN_DURATION (MIN_DURATION)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_tdata_i[2:0]),
    .dt_i        (s_tdata_i[26:3]),
    .idx_i       (s_tdata_i[32:27]),
    .dur_i       (s_tdata_i[58:33]),
    .cur_frame_o (cur_frame),
    .playing_o   (playing),
    .time_o      (time_in_frame),
    .changed_o   (changed)
  );

  assign m_tdata_o = {changed, time_in_frame, playing, cur_frame};

endmodule

`default_nettype wire

// File: rtl/sfs_checker.sv
// Port-level assertions for the sprite frame sequencer, bound to the top level.
`default_nettype none

module sfs_checker
  import sfs_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_tvalid_i,
  input wire logic                  s_tready_o,
  input wire logic                  m_tvalid_o,
  input wire logic                  m_tready_i,
  input wire logic [M_DATA_W-1:0]   m_tdata_o,
  input wire logic                  cfg_we_i
);

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input accepted while previous word still in work");

  // a new result only comes out of a busy period
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(!s_tready_o))
    else $error("result appeared without a word in work");

  // a held result does not vanish
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o))
    else $error("result changed while stalled");

  // registers are written only while the block is empty
  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> s_tready_o && !m_tvalid_o)
    else $error("register written while a word is in flight");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

`default_nettype wire

// File: test/tb_sprite_frame_sequencer.sv
// Self-checking testbench for the sprite frame sequencer, with its own predictor.
`default_nettype none

module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  localparam int          TOTAL_ITEMS = 1550;
  localparam int          SAT_TICKS   = 280;
  localparam int          STALL_LIMIT = 5000;
  localparam int          TAIL_CYCLES = 140;
  localparam int          TABLE_DEPTH = 64;
  localparam int          STEP_CAP    = 128;
  localparam int unsigned SHORTEST    = 1000;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic              changed;
    logic [TIME_W-1:0] tif;
    logic              playing;
    logic [FRAME_W-1:0] frame;
  } status_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [OP_W-1:0]       op;
    logic [DT_W-1:0]       dt;
    logic [IDX_W-1:0]      idx;
    logic [DUR_W-1:0]      dur;
    bit                    typed;
    status_t               want;
  } script_row_t;

  localparam status_t ST_RESET   = '0;
  localparam status_t ST_PLAYING = '{1'b0, 32'd0, 1'b1, 6'd0};

  // Opening sequence: empty clip, three-frame clip through every mode, single-frame ping pong.
  script_row_t opening_script [30] = '{
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_UNUSED_LO, 24'd0, 6'd0, 26'd0, 1'b1, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'hFFFFFF, 6'd0, 26'd0, 1'b1, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_RESTART, 24'd0, 6'd0, 26'd0, 1'b1, ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'hFFFFFF, 6'd0, 26'd0, 1'b1, ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_SELECT, 24'd0, 6'd0, 26'd0, 1'b1, ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_WRITE_DUR, 24'd0, 6'd0, 26'd0, 1'b1, ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_WRITE_DUR, 24'd0, 6'd63, 26'h3FFFFFF, 1'b1,
      ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_WRITE_DUR, 24'd0, 6'd1, 26'd1500, 1'b1, ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_WRITE_DUR, 24'd0, 6'd2, 26'd2000, 1'b1, ST_PLAYING},
    '{ROW_REG, REG_FRAME_COUNT, 7'd3, OP_TICK, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd0, 6'd0, 26'd0, 1'b1, ST_PLAYING},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd999, 6'd0, 26'd0, 1'b1,
      '{1'b0, 32'd999, 1'b1, 6'd0}},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd1, 6'd0, 26'd0, 1'b1,
      '{1'b1, 32'd0, 1'b1, 6'd1}},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'hFFFFFF, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TOGGLE, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd5000, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_SELECT, 24'd0, 6'd3, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_SELECT, 24'd0, 6'd2, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TOGGLE, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_REG, REG_LOOP_MODE, 7'(MODE_ONCE), OP_TICK, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd2000, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_REG, REG_LOOP_MODE, 7'(MODE_HOLD), OP_TICK, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_RESTART, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'hFFFFFF, 6'd0, 26'd0, 1'b1,
      '{1'b1, 32'd2000, 1'b0, 6'd2}},
    '{ROW_REG, REG_LOOP_MODE, 7'(MODE_PING_PONG), OP_TICK, 24'd0, 6'd0, 26'd0, 1'b0,
      ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_RESTART, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd4500, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_REG, REG_FRAME_COUNT, 7'd1, OP_TICK, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_TICK, 24'd1000, 6'd0, 26'd0, 1'b0, ST_RESET},
    '{ROW_WORD, REG_LOOP_MODE, 7'd0, OP_UNUSED_HI, 24'd0, 6'd0, 26'd0, 1'b0, ST_RESET}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  sprite_frame_sequencer dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata),
    .cfg_we_i  (cfg_we),
    .cfg_addr_i(cfg_addr),
    .cfg_data_i(cfg_data)
  );

  // Predictor state
  logic [DUR_W-1:0]  frame_lengths [TABLE_DEPTH];
  bit                length_known  [TABLE_DEPTH];
  int unsigned       anim_pos   = 0;
  logic [TIME_W-1:0] anim_time  = '0;
  bit                anim_back  = 1'b0;
  bit                anim_play  = 1'b0;
  logic [MODE_W-1:0] anim_mode  = MODE_LOOP;
  logic [CNT_W-1:0]  anim_count = '0;

  status_t     due_status [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  logic [15:0] rx_tick     = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clip_len();
    return (anim_count > TABLE_DEPTH) ? TABLE_DEPTH : 32'(anim_count);
  endfunction

  // Lowest frame of the clip whose duration was never written, TABLE_DEPTH if none.
  function automatic int unsigned missing_entry();
    for (int unsigned i = 0; i < clip_len(); i++)
      if (!length_known[i]) return i;
    return TABLE_DEPTH;
  endfunction

  function automatic status_t advance_sequencer(logic [OP_W-1:0] op, logic [DT_W-1:0] dt,
                                                logic [IDX_W-1:0] idx, logic [DUR_W-1:0] dur);
    int unsigned       n;
    int unsigned       steps;
    int unsigned       prior;
    int unsigned       need;
    logic [TIME_W:0]   sum;
    bit                done;
    status_t           res;
    n     = clip_len();
    prior = anim_pos;
    case (op)
      OP_TICK: begin
        if (anim_play && n != 0 && dt != 0) begin
          if (anim_pos > n - 1) anim_pos = n - 1;
          sum       = {1'b0, anim_time} + {{(TIME_W+1-DT_W){1'b0}}, dt};
          anim_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          steps     = 0;
          done      = 1'b0;
          while (!done && steps < STEP_CAP) begin
            need = 32'(frame_lengths[anim_pos]);
            if (need < SHORTEST) need = SHORTEST;
            if (anim_time < need) begin
              done = 1'b1;
            end else begin
              anim_time -= need;
              steps++;
              if (anim_mode == MODE_LOOP) begin
                anim_pos = (anim_pos + 1 == n) ? 0 : anim_pos + 1;
              end else if (anim_mode == MODE_PING_PONG && n > 1) begin
                // bounce off either end
                if (!anim_back) begin
                  if (anim_pos + 1 >= n) begin
                    anim_back = 1'b1;
                    anim_pos  = n - 2;
                  end else begin
                    anim_pos++;
                  end
                end else if (anim_pos == 0) begin
                  anim_back = 1'b0;
                  anim_pos  = 1;
                end else begin
                  anim_pos--;
                end
              end else if (anim_pos + 1 < n) begin
                anim_pos++;
              end else begin
                anim_play = 1'b0;
                anim_time = (anim_mode == MODE_HOLD) ? need : 0;
                done      = 1'b1;
              end
            end
          end
        end
      end
      OP_WRITE_DUR: begin
        frame_lengths[idx] = dur;
        length_known[idx]  = 1'b1;
      end
      OP_RESTART: begin
        anim_pos  = 0;
        anim_back = 1'b0;
        anim_time = '0;
        anim_play = 1'b1;
      end
      OP_TOGGLE: anim_play = !anim_play;
      OP_SELECT: begin
        if (idx < n) begin
          anim_pos  = 32'(idx);
          anim_time = '0;
        end
      end
      default: ;
    endcase
    res.frame   = anim_pos[FRAME_W-1:0];
    res.playing = anim_play;
    res.tif     = anim_time;
    res.changed = (anim_pos != prior);
    return res;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 60) return DUR_W'($urandom_range(0, 3000));
    if (pct < 85) return DUR_W'($urandom_range(3000, 50000));
    return DUR_W'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_word(logic [OP_W-1:0] op, logic [DT_W-1:0] dt, logic [IDX_W-1:0] idx,
                           logic [DUR_W-1:0] dur, bit typed, status_t want);
    int unsigned gap;
    status_t     predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tdata  = {5'd0, dur, idx, dt, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = advance_sequencer(op, dt, idx, dur);
    due_status = {due_status, (typed ? want : predicted)};
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Registers change only once the block has handed back every status word.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    s_tvalid = 1'b0;
    while (due_status.size() != 0) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = sel;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == REG_LOOP_MODE) anim_mode = val[MODE_W-1:0];
    else anim_count = val;
  endtask

  task automatic send_random_item();
    int unsigned      pct;
    int unsigned      hole;
    logic [OP_W-1:0]  op;
    logic [DT_W-1:0]  dt;
    logic [IDX_W-1:0] idx;
    logic [DUR_W-1:0] dur;
    pct = $urandom_range(0, 99);
    dt  = DT_W'($urandom);
    idx = IDX_W'($urandom);
    dur = DUR_W'($urandom);
    if (pct < 55) begin
      op  = OP_TICK;
      pct = $urandom_range(0, 99);
      if (pct < 10) dt = '0;
      else if (pct < 60) dt = DT_W'($urandom_range(1, 5000));
      else if (pct < 85) dt = DT_W'($urandom_range(5000, 200000));
    end else if (pct < 67) begin
      op  = OP_WRITE_DUR;
      dur = pick_duration();
      if ($urandom_range(0, 1) == 0) idx = IDX_W'($urandom_range(0, 15));
    end else if (pct < 75) begin
      op = OP_RESTART;
    end else if (pct < 83) begin
      op = OP_TOGGLE;
    end else if (pct < 93) begin
      op = OP_SELECT;
      if ($urandom_range(0, 9) < 7) idx = IDX_W'($urandom_range(0, 15));
    end else begin
      op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    // a tick that would step must not read a duration that was never written
    hole = missing_entry();
    if (op == OP_TICK && anim_play && clip_len() != 0 && dt != 0 && hole < TABLE_DEPTH) begin
      op  = OP_WRITE_DUR;
      idx = IDX_W'(hole);
      dur = pick_duration();
    end
    push_word(op, dt, idx, dur, 1'b0, ST_RESET);
  endtask

  // Receiver backpressure: cycles through always-ready, random, sparse and long-stall stretches.
  always @(negedge clk) begin
    rx_tick++;
    case (rx_tick[9:8])
      2'd0: m_tready = 1'b1;
      2'd1: m_tready = ($urandom_range(0, 3) != 0);
      2'd2: m_tready = (rx_tick[2:0] < 3'd2);
      default: m_tready = (rx_tick[5:0] >= 6'd40);
    endcase
  end

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        got = status_t'(m_tdata);
        if (due_status.size() == 0) begin
          $display("%0t: expected no word, got %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = due_status.pop_front();
          compare_field("current_frame", want.frame, got.frame);
          compare_field("is_playing", want.playing, got.playing);
          compare_field("time_in_frame", want.tif, got.tif);
          compare_field("frame_changed", want.changed, got.changed);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned mode_pick;
    int unsigned phase_len;
    logic [CNT_W-1:0] count_pick;
    foreach (length_known[i]) length_known[i] = 1'b0;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (opening_script[r]) begin
      if (opening_script[r].kind == ROW_REG)
        write_reg(opening_script[r].reg_sel, opening_script[r].reg_val);
      else
        push_word(opening_script[r].op, opening_script[r].dt, opening_script[r].idx,
                  opening_script[r].dur, opening_script[r].typed, opening_script[r].want);
    end

    // Full clip of minimum durations with maximum ticks: frame time climbs into saturation.
    write_reg(REG_LOOP_MODE, CFG_DATA_W'(MODE_LOOP));
    write_reg(REG_FRAME_COUNT, 7'd127);
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_word(OP_WRITE_DUR, DT_W'($urandom), IDX_W'(i), DUR_W'($urandom_range(0, 999)),
                1'b0, ST_RESET);
    push_word(OP_RESTART, '0, '0, '0, 1'b0, ST_RESET);
    repeat (SAT_TICKS) push_word(OP_TICK, 24'hFFFFFF, IDX_W'($urandom), DUR_W'($urandom),
                                 1'b0, ST_RESET);

    while (items_sent < TOTAL_ITEMS) begin
      mode_pick = $urandom_range(0, 3);
      write_reg(REG_LOOP_MODE, {5'($urandom_range(0, 31)), 2'(mode_pick)});
      case ($urandom_range(0, 9))
        0: count_pick = 7'd0;
        1: count_pick = 7'd1;
        2: count_pick = 7'd64;
        3: count_pick = 7'd127;
        4: count_pick = CNT_W'($urandom_range(65, 126));
        5, 6: count_pick = CNT_W'($urandom_range(2, 4));
        default: count_pick = CNT_W'($urandom_range(2, 12));
      endcase
      write_reg(REG_FRAME_COUNT, count_pick);
      if ($urandom_range(0, 3) != 0) push_word(OP_RESTART, '0, '0, '0, 1'b0, ST_RESET);
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) send_random_item();
    end
    s_tvalid = 1'b0;

    while (due_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/sfs_pkg.sv
rtl/sfs_ctrl.sv
rtl/sfs_datapath.sv
rtl/sprite_frame_sequencer.sv
rtl/sfs_checker.sv
test/tb_sprite_frame_sequencer.sv
